[rtl/core/sctd_pkg.sv]
// ----------------------------------------------------------------------------
// sctd_pkg: shared types and constants for the self-calibrating tick delay
// Widths, codes, controller states and the request/response bundles of the
// serial multiply and divide units.
// ----------------------------------------------------------------------------
package sctd_pkg;

    localparam int DLY_W   = 31;           // delay / config register width
    localparam int TPS_W   = 16;           // tick rate and tick counter
    localparam int TIME_W  = 32;           // millisecond time base
    localparam int MAG_W   = 32;           // signed magnitude operand
    localparam int PROD_W  = MAG_W + DLY_W; // 63-bit product / dividend
    localparam int DRT_W   = 15;           // elapsed ms after resync check
    localparam int CNT_W   = 5;            // serial step counter

    localparam logic [CNT_W-1:0]  SER_STEPS     = CNT_W'(DLY_W);
    localparam logic [TIME_W-1:0] GAP_RESYNC_MS = 32'd30000;
    localparam logic [TIME_W-1:0] MS_PER_SEC    = 32'd1000;
    localparam logic [DLY_W-1:0]  STOPPED_DELAY = 31'd10000;
    localparam logic [DLY_W-1:0]  FALLBACK_TPS  = 31'd100;
    localparam logic [DLY_W-1:0]  DLY_MAX       = 31'h7FFF_FFFF;
    localparam logic [DLY_W-1:0]  DLY_ONE       = 31'd1;
    localparam logic [MAG_W-1:0]  MAG_NEG_SAT   = 32'h8000_0000;
    localparam logic [DLY_W-1:0]  MAX_GAP_RST   = 31'd500;
    localparam logic [DLY_W-1:0]  INIT_IPS_RST  = 31'd500000;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP_MS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_IPS = 1'b1;

    // action codes
    localparam logic ACT_INIT = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef enum logic [2:0] {
        OC_INIT       = 3'd0,
        OC_COUNTING   = 3'd1,
        OC_STOPPED    = 3'd2,
        OC_WRAP       = 3'd3,
        OC_RESYNC     = 3'd4,
        OC_CALIBRATED = 3'd5
    } t_outcome;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_RS_MUL,
        S_RS_DIV,
        S_TICK,
        S_GAP_DIFF,
        S_GAP_CLAMP,
        S_GAP_NI,
        S_CAL_MUL1,
        S_CAL_DIV1,
        S_CAL_MUL2,
        S_CAL_DIV2,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] a;
        logic [DLY_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] product;
    } t_mul_rsp;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [MAG_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic             sat;    // quotient >= 2^31
        logic [DLY_W-1:0] quot;
    } t_div_rsp;

endpackage

[rtl/core/sctd_in_if.sv]
// ----------------------------------------------------------------------------
// sctd_in_if: input item channel
// Valid/ready handshake carrying one loop command per transaction.
// ----------------------------------------------------------------------------
interface sctd_in_if import sctd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              action;
    logic [TPS_W-1:0]  ticks_per_sec;
    logic [TIME_W-1:0] now_ms;
    logic [DLY_W-1:0]  init_delay;

    modport source (output valid, action, ticks_per_sec, now_ms, init_delay,
                    input ready);
    modport sink   (input valid, action, ticks_per_sec, now_ms, init_delay,
                    output ready);
endinterface

[rtl/core/sctd_out_if.sv]
// ----------------------------------------------------------------------------
// sctd_out_if: result item channel
// Valid/ready handshake carrying the new delay and its outcome code.
// ----------------------------------------------------------------------------
interface sctd_out_if import sctd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [DLY_W-1:0] delay;
    logic [2:0]       outcome;

    modport source (output valid, delay, outcome, input ready);
    modport sink   (input valid, delay, outcome, output ready);
endinterface

[rtl/core/sctd_mul.sv]
// ----------------------------------------------------------------------------
// sctd_mul: bit-serial unsigned multiplier
// 32 x 31 shift-add, one multiplier bit per cycle, 63-bit exact product.
// ----------------------------------------------------------------------------
module sctd_mul import sctd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [MAG_W-1:0]  r_a;
    logic [PROD_W-1:0] r_prod;
    logic [MAG_W:0]    n_sum;

    // high half plus multiplicand when the current multiplier bit is set
    always_comb begin
        n_sum = {1'b0, r_prod[PROD_W-1:DLY_W]} + (r_prod[0] ? {1'b0, r_a} : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= SER_STEPS;
            end else if (r_busy) begin
                r_cnt  <= r_cnt - 1'b1;
                r_busy <= (r_cnt != CNT_W'(1));
                r_done <= (r_cnt == CNT_W'(1));
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a    <= i_req.a;
            r_prod <= {{MAG_W{1'b0}}, i_req.b};
        end else if (r_busy) begin
            r_prod <= {n_sum, r_prod[DLY_W-1:1]};
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.product = r_prod;

endmodule

[rtl/core/sctd_div.sv]
// ----------------------------------------------------------------------------
// sctd_div: bit-serial restoring divider with int32 saturation detect
// 63-bit dividend by 32-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sctd_div import sctd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_sat;
    logic [MAG_W-1:0]  r_rem;
    logic [MAG_W-1:0]  r_d;
    logic [DLY_W-1:0]  r_q;     // dividend bits out, quotient bits in
    logic [MAG_W:0]    n_trial;
    logic [MAG_W+1:0]  n_diff;
    logic              n_ge;
    logic              n_sat;

    // quotient overflows 31 bits when the high half already reaches the divisor
    assign n_sat = (i_req.dividend[PROD_W-1:DLY_W] >= i_req.divisor);

    always_comb begin
        n_trial = {r_rem, r_q[DLY_W-1]};
        n_diff  = {1'b0, n_trial} - {2'b00, r_d};
        n_ge    = ~n_diff[MAG_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_req.start) begin
                r_busy <= ~n_sat;
                r_done <= n_sat;
                r_cnt  <= SER_STEPS;
            end else if (r_busy) begin
                r_cnt  <= r_cnt - 1'b1;
                r_busy <= (r_cnt != CNT_W'(1));
                r_done <= (r_cnt == CNT_W'(1));
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_sat <= n_sat;
            r_d   <= i_req.divisor;
            r_rem <= i_req.dividend[PROD_W-1:DLY_W];
            r_q   <= i_req.dividend[DLY_W-1:0];
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[MAG_W-1:0] : n_trial[MAG_W-1:0];
            r_q   <= {r_q[DLY_W-2:0], n_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.sat  = r_sat;
    assign o_rsp.quot = r_q;

endmodule

[rtl/core/self_calibrating_tick_delay.sv]
// ----------------------------------------------------------------------------
// self_calibrating_tick_delay: instructions-per-tick regulator
// Keeps emulated clock ticks in step with wall-clock time.
// ----------------------------------------------------------------------------
// i_in   : one command per transaction; action 0 seeds the loop from
//          init_delay and now_ms, action 1 reports one tick with rate and clock.
// o_out  : exactly one result per command: the delay and an outcome code.
// i_cfg_*: writes max_gap_ms (index 0) and initial_ips (index 1); write only
//          while no command is in flight.
// Flow, accept to result valid: an init goes from evaluation to the result;
// a stopped or counting tick also passes the tick step. A rate change that
// rescales the delay adds one serial multiply and one serial divide. The
// once-per-second calibration adds 3 gap clamp steps plus two multiplies and
// two divides on the shared bit-serial units; a divide that saturates ends
// without its serial steps. One command at a time: the next one can be
// accepted in the cycle after the result is loaded.
// Reset: synchronous, active low; loop state clears, config returns to
// 500 ms and 500000 instructions/s.
// Stall: the result waits in an output register and a new command is accepted
// meanwhile; a second result holds in the controller until the first one is
// taken, and no further command is accepted.
// ----------------------------------------------------------------------------
module self_calibrating_tick_delay import sctd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DLY_W-1:0]     i_cfg_data,
    sctd_in_if.sink              i_in,
    sctd_out_if.source           o_out
);

    // controller
    t_state r_state;
    t_state n_state;

    // configuration
    logic [DLY_W-1:0] r_max_gap_ms;
    logic [DLY_W-1:0] r_initial_ips;

    // loop state
    logic [TPS_W-1:0]  r_tick_count;
    logic [TPS_W-1:0]  r_rate_hz;
    logic [TPS_W-1:0]  r_prior_rate_hz;
    logic [TIME_W-1:0] r_real_time_ms;
    logic [TIME_W-1:0] r_virtual_time_ms;
    logic [TIME_W-1:0] r_next_interval;   // signed
    logic [DLY_W-1:0]  r_base_delay;      // never negative once stored
    logic [DLY_W-1:0]  r_current_delay;

    // latched command
    logic              r_action;
    logic [TPS_W-1:0]  r_tps;
    logic [TIME_W-1:0] r_now;
    logic [DLY_W-1:0]  r_seed;

    // calibration scratch
    logic [DRT_W-1:0]  r_drt;
    logic [TIME_W-1:0] r_gap;             // signed
    logic [TIME_W-1:0] r_ni_new;          // signed
    logic              r_sign1;
    logic              r_sign2;

    // pending result and output register
    logic [DLY_W-1:0]  r_res_delay;
    t_outcome          r_res_outcome;
    logic              r_out_valid;
    logic [DLY_W-1:0]  r_out_delay;
    t_outcome          r_out_outcome;

    // serial arithmetic units
    t_mul_req mul_req;
    t_mul_rsp mul_rsp;
    t_div_req div_req;
    t_div_rsp div_rsp;

    sctd_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    sctd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // ------------------------------------------------------------------
    // Decision logic
    // ------------------------------------------------------------------
    logic              in_fire;
    logic              out_load;
    logic              rescale;
    logic [TPS_W-1:0]  tick_inc;
    logic [TIME_W-1:0] drt;
    logic              wrap;
    logic              drt_big;
    logic              drt_zero;
    logic [TIME_W-1:0] ni_old_neg;
    logic [DLY_W-1:0]  ni_old_mag;
    logic [TIME_W-1:0] ni_new_neg;
    logic [DLY_W-1:0]  ni_new_mag;
    logic [TIME_W:0]   gap_ext;
    logic [TIME_W:0]   lim_ext;
    logic [TIME_W:0]   lim_neg;
    logic [TIME_W:0]   ni_sum;
    logic [MAG_W-1:0]  bnew_mag;
    logic              bnew_nonpos;
    logic [DLY_W-1:0]  seed_eff;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_load = (r_state == S_PUSH) && (!r_out_valid || o_out.ready);

    // rescale only on a change to a nonzero rate that differs from a
    // nonzero prior rate
    assign rescale = (r_rate_hz != r_tps) && (r_prior_rate_hz != '0)
                     && (r_prior_rate_hz != r_tps) && (r_tps != '0);

    assign tick_inc = r_tick_count + 1'b1;
    assign drt      = r_now - r_real_time_ms;
    assign wrap     = r_now < r_real_time_ms;
    assign drt_big  = drt > GAP_RESYNC_MS;
    assign drt_zero = (r_drt == '0);

    // interval magnitudes (an interval never reaches -2^31)
    assign ni_old_neg = '0 - r_next_interval;
    assign ni_old_mag = r_next_interval[TIME_W-1] ? ni_old_neg[DLY_W-1:0]
                                                  : r_next_interval[DLY_W-1:0];
    assign ni_new_neg = '0 - r_ni_new;
    assign ni_new_mag = r_ni_new[TIME_W-1] ? ni_new_neg[DLY_W-1:0]
                                           : r_ni_new[DLY_W-1:0];

    // gap clamp to +/- max_gap_ms, then 1000 + gap saturated
    assign gap_ext = {r_gap[TIME_W-1], r_gap};
    assign lim_ext = {2'b00, r_max_gap_ms};
    assign lim_neg = '0 - lim_ext;
    assign ni_sum  = gap_ext + {1'b0, MS_PER_SEC};

    // new base delay as sign + magnitude, int32 saturated
    always_comb begin
        if (div_rsp.sat) begin
            bnew_mag = r_sign1 ? MAG_NEG_SAT : {1'b0, DLY_MAX};
        end else begin
            bnew_mag = {1'b0, div_rsp.quot};
        end
        bnew_nonpos = r_sign1 || (bnew_mag == '0);
    end

    // a loop that already runs keeps its delay across re-init
    always_comb begin
        if (r_current_delay != '0) begin
            seed_eff = r_current_delay;
        end else if (r_seed == '0) begin
            seed_eff = DLY_ONE;
        end else begin
            seed_eff = r_seed;
        end
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) n_state = S_EVAL;
            end
            S_EVAL: begin
                if (r_action == ACT_INIT) n_state = S_PUSH;
                else if (rescale)         n_state = S_RS_MUL;
                else                      n_state = S_TICK;
            end
            S_RS_MUL: begin
                if (mul_rsp.done) n_state = S_RS_DIV;
            end
            S_RS_DIV: begin
                if (div_rsp.done) n_state = S_TICK;
            end
            S_TICK: begin
                if (r_tps == '0 || tick_inc < r_tps || wrap || drt_big) begin
                    n_state = S_PUSH;
                end else begin
                    n_state = S_GAP_DIFF;
                end
            end
            S_GAP_DIFF:  n_state = S_GAP_CLAMP;
            S_GAP_CLAMP: n_state = S_GAP_NI;
            S_GAP_NI:    n_state = S_CAL_MUL1;
            S_CAL_MUL1: begin
                if (mul_rsp.done) n_state = S_CAL_DIV1;
            end
            S_CAL_DIV1: begin
                if (div_rsp.done) n_state = S_CAL_MUL2;
            end
            S_CAL_MUL2: begin
                if (mul_rsp.done) n_state = S_CAL_DIV2;
            end
            S_CAL_DIV2: begin
                if (div_rsp.done) n_state = S_PUSH;
            end
            S_PUSH: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Controller outputs: handshake and arithmetic unit launches
    // ------------------------------------------------------------------
    always_comb begin
        i_in.ready       = 1'b0;
        mul_req.start    = 1'b0;
        mul_req.a        = '0;
        mul_req.b        = '0;
        div_req.start    = 1'b0;
        div_req.dividend = mul_rsp.product;
        div_req.divisor  = {{(MAG_W-DLY_W){1'b0}}, DLY_ONE};
        unique case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
            end
            S_EVAL: begin
                // ips estimate: delay * rate, else delay * 100, else initial_ips
                mul_req.start = (r_action == ACT_TICK) && rescale;
                if (r_current_delay == '0) begin
                    mul_req.a = {1'b0, r_initial_ips};
                    mul_req.b = DLY_ONE;
                end else begin
                    mul_req.a = {1'b0, r_current_delay};
                    mul_req.b = (r_rate_hz == '0) ? FALLBACK_TPS
                                                  : {{(DLY_W-TPS_W){1'b0}}, r_rate_hz};
                end
            end
            S_RS_MUL: begin
                div_req.start   = mul_rsp.done;
                div_req.divisor = {{(MAG_W-TPS_W){1'b0}}, r_tps};
            end
            S_GAP_NI: begin
                // base * interval, or base * rate when no time elapsed
                mul_req.start = 1'b1;
                mul_req.a     = {1'b0, r_base_delay};
                mul_req.b     = drt_zero ? {{(DLY_W-TPS_W){1'b0}}, r_tps} : ni_old_mag;
            end
            S_CAL_MUL1: begin
                div_req.start   = mul_rsp.done;
                div_req.divisor = drt_zero ? {{(MAG_W-DLY_W){1'b0}}, DLY_ONE}
                                           : {{(MAG_W-DRT_W){1'b0}}, r_drt};
            end
            S_CAL_DIV1: begin
                mul_req.start = div_rsp.done;
                mul_req.a     = bnew_mag;
                mul_req.b     = ni_new_mag;
            end
            S_CAL_MUL2: begin
                div_req.start   = mul_rsp.done;
                div_req.divisor = MS_PER_SEC;
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control and loop state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= S_IDLE;
            r_max_gap_ms      <= MAX_GAP_RST;
            r_initial_ips     <= INIT_IPS_RST;
            r_tick_count      <= '0;
            r_rate_hz         <= '0;
            r_prior_rate_hz   <= '0;
            r_real_time_ms    <= '0;
            r_virtual_time_ms <= '0;
            r_next_interval   <= '0;
            r_base_delay      <= '0;
            r_current_delay   <= '0;
            r_out_valid       <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MAX_GAP_MS:  r_max_gap_ms  <= i_cfg_data;
                    CFG_INITIAL_IPS: r_initial_ips <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_EVAL: begin
                    if (r_action == ACT_INIT) begin
                        r_real_time_ms    <= r_now;
                        r_virtual_time_ms <= r_now;
                        r_next_interval   <= MS_PER_SEC;
                        r_tick_count      <= '0;
                        r_prior_rate_hz   <= r_rate_hz;
                        r_rate_hz         <= '0;
                        r_base_delay      <= seed_eff;
                        r_current_delay   <= seed_eff;
                    end else if (r_rate_hz != r_tps) begin
                        r_prior_rate_hz <= r_rate_hz;
                        r_rate_hz       <= r_tps;
                    end
                end
                S_RS_DIV: begin
                    if (div_rsp.done) begin
                        r_current_delay <= div_rsp.sat ? DLY_MAX : div_rsp.quot;
                    end
                end
                S_TICK: begin
                    if (r_tps != '0) begin
                        if (tick_inc < r_tps) begin
                            r_tick_count <= tick_inc;
                        end else begin
                            r_tick_count   <= '0;
                            r_real_time_ms <= r_now;
                            if (wrap || drt_big) begin
                                // wall clock wrapped or fell far behind
                                r_virtual_time_ms <= r_now;
                                r_next_interval   <= MS_PER_SEC;
                                r_base_delay      <= r_current_delay;
                            end else begin
                                r_virtual_time_ms <= r_virtual_time_ms + MS_PER_SEC;
                            end
                        end
                    end
                end
                S_CAL_DIV1: begin
                    if (div_rsp.done) begin
                        r_base_delay <= bnew_nonpos ? DLY_ONE : bnew_mag[DLY_W-1:0];
                    end
                end
                S_CAL_DIV2: begin
                    if (div_rsp.done) begin
                        r_next_interval <= r_ni_new;
                        if (r_sign2 || (!div_rsp.sat && div_rsp.quot == '0)) begin
                            r_current_delay <= DLY_ONE;
                        end else begin
                            r_current_delay <= div_rsp.sat ? DLY_MAX : div_rsp.quot;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Payload: latched command, scratch, result
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_action <= i_in.action;
            r_tps    <= i_in.ticks_per_sec;
            r_now    <= i_in.now_ms;
            r_seed   <= i_in.init_delay;
        end

        if (out_load) begin
            r_out_delay   <= r_res_delay;
            r_out_outcome <= r_res_outcome;
        end

        case (r_state)
            S_EVAL: begin
                r_res_delay   <= seed_eff;
                r_res_outcome <= OC_INIT;
            end
            S_TICK: begin
                r_drt <= drt[DRT_W-1:0];
                if (r_tps == '0) begin
                    r_res_delay   <= STOPPED_DELAY;
                    r_res_outcome <= OC_STOPPED;
                end else begin
                    r_res_delay <= r_current_delay;
                    if (tick_inc < r_tps) r_res_outcome <= OC_COUNTING;
                    else if (wrap)        r_res_outcome <= OC_WRAP;
                    else                  r_res_outcome <= OC_RESYNC;
                end
            end
            S_GAP_DIFF: begin
                r_gap <= r_virtual_time_ms - r_real_time_ms;
            end
            S_GAP_CLAMP: begin
                if ($signed(gap_ext) > $signed(lim_ext)) begin
                    r_gap <= lim_ext[TIME_W-1:0];
                end else if ($signed(gap_ext) < $signed(lim_neg)) begin
                    r_gap <= lim_neg[TIME_W-1:0];
                end
            end
            S_GAP_NI: begin
                // only positive overflow is possible
                r_ni_new <= (!ni_sum[TIME_W] && ni_sum[TIME_W-1]) ? {1'b0, DLY_MAX}
                                                                  : ni_sum[TIME_W-1:0];
                r_sign1  <= !drt_zero && r_next_interval[TIME_W-1];
            end
            S_CAL_DIV1: begin
                r_sign2 <= r_sign1 ^ r_ni_new[TIME_W-1];
            end
            S_CAL_DIV2: begin
                if (r_sign2 || (!div_rsp.sat && div_rsp.quot == '0)) begin
                    r_res_delay <= DLY_ONE;
                end else begin
                    r_res_delay <= div_rsp.sat ? DLY_MAX : div_rsp.quot;
                end
                r_res_outcome <= OC_CALIBRATED;
            end
            default: begin
            end
        endcase
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.delay   = r_out_delay;
    assign o_out.outcome = r_out_outcome;

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for self_calibrating_tick_delay
// Drives loop commands over the input channel and predicts each delay and
// outcome with an independent integer model of the regulation loop. Every
// result is checked in order. The run walks several register settings and
// back-pressure mixes.
// ----------------------------------------------------------------------------
module tb;
    import sctd_pkg::*;

    // Run shape
    localparam int PER_PHASE   = 112;   // random commands per register setting
    localparam int HOLD_CYCLES = 400;   // long receiver hold-off
    localparam int TAIL_CYCLES = 200;   // settle time after the last result
    localparam int QUIET_LIMIT = 4000;  // cycles without any transaction

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    // One loop command as it travels on the input channel
    typedef struct packed {
        logic              action;
        logic [TPS_W-1:0]  ticks_per_sec;
        logic [TIME_W-1:0] now_ms;
        logic [DLY_W-1:0]  init_delay;
    } t_loop_cmd;

    // One predicted result
    typedef struct packed {
        logic [DLY_W-1:0] delay;
        t_outcome         outcome;
    } t_tick_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Config write port, driven only by the sequencing block
    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx  = CFG_MAX_GAP_MS;
    logic [DLY_W-1:0]     cfg_data = '0;

    // Channel drive state
    logic      drv_valid = 1'b0;
    t_loop_cmd drv_cmd   = '0;
    logic      rdy       = 1'b0;
    logic      in_taken  = 1'b0;

    sctd_in_if  in_if ();
    sctd_out_if out_if ();

    assign in_if.valid         = drv_valid;
    assign in_if.action        = drv_cmd.action;
    assign in_if.ticks_per_sec = drv_cmd.ticks_per_sec;
    assign in_if.now_ms        = drv_cmd.now_ms;
    assign in_if.init_delay    = drv_cmd.init_delay;
    assign out_if.ready        = rdy;

    self_calibrating_tick_delay DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Bookkeeping shared between the sequencer, driver and monitor
    t_loop_cmd    cmd_q[$];         // commands waiting for the driver
    t_tick_result result_due_q[$];  // predicted results, oldest first
    int           n_queued  = 0;
    int           n_checked = 0;
    int           n_fail    = 0;
    int           n_quiet   = 0;
    t_idle_mode   idle_mode = IDLE_NONE;
    int           hold_token = 0;
    int           hold_seen  = 0;
    int           hold_left  = 0;

    // Stimulus generator state: running wall clock and tick rate
    logic [TIME_W-1:0] gen_now = '0;
    int                sec_tps = 2;

    // ------------------------------------------------------------------------
    // Loop predictor: private copy of the regulator state and registers.
    // Products are carried in 64-bit signed arithmetic so they stay exact
    // and division truncates toward zero.
    // ------------------------------------------------------------------------
    logic [DLY_W-1:0]  p_max_gap  = MAX_GAP_RST;
    logic [DLY_W-1:0]  p_init_ips = INIT_IPS_RST;
    logic [TPS_W-1:0]  p_tick_cnt = '0;
    logic [TPS_W-1:0]  p_rate     = '0;
    logic [TPS_W-1:0]  p_prior    = '0;
    logic [TIME_W-1:0] p_real_ms  = '0;
    logic [TIME_W-1:0] p_virt_ms  = '0;
    int                p_next_ivl = 0;
    int                p_base     = 0;
    int                p_cur      = 0;

    function automatic int clip_i32(input longint v);
        if (v > longint'(32'sh7FFF_FFFF))
            return 32'sh7FFF_FFFF;
        if (v < -longint'(32'sh7FFF_FFFF) - 1)
            return 32'sh8000_0000;
        return int'(v);
    endfunction

    function automatic t_tick_result regulate_tick(input t_loop_cmd c);
        t_tick_result      r;
        int                seed;
        longint            ips;
        longint            gap;
        longint            lim;
        logic [TIME_W-1:0] drt;
        logic [TIME_W-1:0] dv;
        seed = int'(c.init_delay);
        if (c.action == ACT_INIT) begin
            // a running delay takes priority over the offered seed
            if (seed == 0)
                seed = 1;
            if (p_cur != 0)
                seed = p_cur;
            p_real_ms  = c.now_ms;
            p_virt_ms  = c.now_ms;
            p_next_ivl = int'(MS_PER_SEC);
            p_tick_cnt = '0;
            p_prior    = p_rate;
            p_rate     = '0;
            p_base     = seed;
            p_cur      = seed;
            r.delay    = seed[DLY_W-1:0];
            r.outcome  = OC_INIT;
            return r;
        end
        if (p_rate != c.ticks_per_sec) begin
            if (p_prior != 0 && p_prior != c.ticks_per_sec && c.ticks_per_sec != 0) begin
                // instructions-per-second estimate, with two fallbacks
                ips = longint'(p_cur) * longint'(p_rate);
                if (ips == 0)
                    ips = longint'(p_cur) * longint'(FALLBACK_TPS);
                if (ips == 0)
                    ips = longint'(p_init_ips);
                p_cur = clip_i32(ips / longint'(c.ticks_per_sec));
            end
            p_prior = p_rate;
            p_rate  = c.ticks_per_sec;
        end
        if (c.ticks_per_sec == 0) begin
            r.delay   = STOPPED_DELAY;
            r.outcome = OC_STOPPED;
            return r;
        end
        p_tick_cnt = p_tick_cnt + 16'd1;
        if (p_tick_cnt < c.ticks_per_sec) begin
            r.delay   = p_cur[DLY_W-1:0];
            r.outcome = OC_COUNTING;
            return r;
        end
        p_tick_cnt = '0;
        if (c.now_ms < p_real_ms) begin
            // wall clock went backwards: rebase both time lines
            p_real_ms  = c.now_ms;
            p_virt_ms  = c.now_ms;
            p_next_ivl = int'(MS_PER_SEC);
            p_base     = p_cur;
            r.delay    = p_cur[DLY_W-1:0];
            r.outcome  = OC_WRAP;
            return r;
        end
        drt       = c.now_ms - p_real_ms;
        p_real_ms = c.now_ms;
        p_virt_ms = p_virt_ms + MS_PER_SEC;
        if (drt > GAP_RESYNC_MS) begin
            p_virt_ms  = p_real_ms;
            p_next_ivl = int'(MS_PER_SEC);
            p_base     = p_cur;
            r.delay    = p_cur[DLY_W-1:0];
            r.outcome  = OC_RESYNC;
            return r;
        end
        if (drt == 0)
            p_base = clip_i32(longint'(p_base) * longint'(c.ticks_per_sec));
        else
            p_base = clip_i32(longint'(p_base) * longint'(p_next_ivl) / longint'(drt));
        // signed virtual-minus-real gap, clamped to the register limit
        dv  = p_virt_ms - p_real_ms;
        gap = longint'($signed(dv));
        lim = longint'(p_max_gap);
        if (gap > lim)
            gap = lim;
        else if (gap < -lim)
            gap = -lim;
        p_next_ivl = clip_i32(longint'(MS_PER_SEC) + gap);
        p_cur = clip_i32(longint'(p_base) * longint'(p_next_ivl) / longint'(MS_PER_SEC));
        if (p_base <= 0)
            p_base = 1;
        if (p_cur <= 0)
            p_cur = 1;
        r.delay   = p_cur[DLY_W-1:0];
        r.outcome = OC_CALIBRATED;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: presents the next queued command at the falling edge once the
    // current one has been taken, with random gaps in the idling phases.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        int pct;
        pct = (idle_mode == IDLE_SEND) ? 47 : (idle_mode == IDLE_BOTH) ? 29 : 0;
        if (!drv_valid || in_taken) begin
            if (cmd_q.size() != 0 && $urandom_range(0, 99) >= pct) begin
                drv_cmd   <= cmd_q.pop_front();
                drv_valid <= 1'b1;
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        int pct;
        pct = (idle_mode == IDLE_RECV) ? 47 : (idle_mode == IDLE_BOTH) ? 29 : 0;
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rdy       <= 1'b0;
        end else if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            rdy       <= 1'b0;
        end else begin
            rdy <= ($urandom_range(0, 99) >= pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: every accepted command feeds the predictor; every accepted
    // result is checked against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_tick_result due;
        t_loop_cmd    seen;
        in_taken <= i_rst_n && in_if.valid && in_if.ready;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                seen = '{in_if.action, in_if.ticks_per_sec, in_if.now_ms, in_if.init_delay};
                result_due_q.push_back(regulate_tick(seen));
            end
            if (out_if.valid && out_if.ready) begin
                n_checked++;
                if (result_due_q.size() == 0) begin
                    $error("unexpected result: delay %0d outcome %0d",
                           out_if.delay, out_if.outcome);
                    n_fail++;
                end else begin
                    due = result_due_q.pop_front();
                    if (out_if.delay !== due.delay) begin
                        $error("delay mismatch: expected %0d, got %0d",
                               due.delay, out_if.delay);
                        n_fail++;
                    end
                    if (out_if.outcome !== due.outcome) begin
                        $error("outcome mismatch: expected %0d, got %0d",
                               due.outcome, out_if.outcome);
                        n_fail++;
                    end
                end
            end
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                n_quiet <= 0;
            else
                n_quiet <= n_quiet + 1;
        end
    end

    // Watchdog: too long without a transaction on either channel
    initial begin
        while (n_quiet < QUIET_LIMIT)
            @(negedge i_clk);
        $display("tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sequencing helpers
    // ------------------------------------------------------------------------
    task automatic queue_cmd(input logic act, input logic [TPS_W-1:0] tps,
                             input logic [TIME_W-1:0] now, input logic [DLY_W-1:0] seed);
        cmd_q.push_back('{act, tps, now, seed});
        n_queued++;
    endtask

    // Register write; the predictor copy follows at once since nothing is
    // in flight when this is called.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DLY_W-1:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        if (idx == CFG_MAX_GAP_MS)
            p_max_gap = val;
        else
            p_init_ips = val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (n_checked != n_queued)
            @(negedge i_clk);
    endtask

    // Random traffic: mostly whole emulated seconds (tps ticks whose last one
    // lands a span of wall time later), with inits and stray ticks mixed in.
    task automatic queue_traffic(input int n);
        logic [TPS_W-1:0]  tps;
        logic [TIME_W-1:0] now_v;
        logic [TIME_W-1:0] base_now;
        logic [DLY_W-1:0]  seed;
        int                left;
        int                r;
        int                span;
        int                j;
        left = n;
        while (left > 0) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                if ($urandom_range(0, 1) == 1)
                    gen_now = $urandom();
                case ($urandom_range(0, 4))
                    0: seed = '0;
                    1: seed = DLY_ONE;
                    2: seed = DLY_W'($urandom_range(1, 100000));
                    3: seed = DLY_MAX;
                    default: seed = DLY_W'($urandom());
                endcase
                queue_cmd(ACT_INIT, TPS_W'($urandom()), gen_now, seed);
                left--;
            end else if (r < 16) begin
                // stray tick: stopped clock or any rate, any wall time
                tps   = ($urandom_range(0, 2) == 0) ? '0 : TPS_W'($urandom());
                now_v = ($urandom_range(0, 1) == 1) ? $urandom() : gen_now;
                queue_cmd(ACT_TICK, tps, now_v, DLY_W'($urandom()));
                left--;
            end else begin
                if ($urandom_range(0, 3) == 0)
                    sec_tps = $urandom_range(1, 6);
                case ($urandom_range(0, 19))
                    0: span = 0;                                // no time passed
                    1: span = $urandom_range(30001, 200000);    // beyond resync
                    2: span = 30000;                            // resync boundary
                    3: span = -$urandom_range(1, 5000);         // clock goes back
                    4: span = $urandom_range(0, 6000);
                    default: span = $urandom_range(400, 1600);
                endcase
                base_now = gen_now;
                for (j = 1; j <= sec_tps; j++)
                    queue_cmd(ACT_TICK, TPS_W'(sec_tps),
                              base_now + TIME_W'((span * j) / sec_tps),
                              DLY_W'($urandom()));
                gen_now = base_now + TIME_W'(span);
                left -= sec_tps;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [DLY_W-1:0] gap_v;
        logic [DLY_W-1:0] ips_v;
        int               ph;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed walk at reset register values, no idling
        queue_cmd(ACT_TICK, 16'd0,      32'd0,          DLY_MAX);      // stopped before init
        queue_cmd(ACT_INIT, 16'hFFFF,   32'd0,          '0);           // zero seed -> 1
        queue_cmd(ACT_INIT, 16'd0,      32'd7,          DLY_MAX);      // re-init keeps delay
        queue_cmd(ACT_TICK, 16'd1,      32'd1000,       '0);           // one-tick second
        queue_cmd(ACT_TICK, 16'd2,      32'd1000,       '0);
        queue_cmd(ACT_TICK, 16'd3,      32'd1000,       '0);           // rescale down to 0
        queue_cmd(ACT_TICK, 16'd4,      32'd1000,       '0);           // estimate from register
        queue_cmd(ACT_TICK, 16'd4,      32'd2000,       '0);
        queue_cmd(ACT_TICK, 16'd5,      32'd2000,       '0);
        queue_cmd(ACT_INIT, 16'd0,      32'd2000,       DLY_MAX);      // largest seed
        queue_cmd(ACT_TICK, 16'd2,      32'd2000,       '0);           // saturating rescale
        queue_cmd(ACT_TICK, 16'd2,      32'd3000,       '0);
        queue_cmd(ACT_TICK, 16'd2,      32'd3000,       '0);
        queue_cmd(ACT_TICK, 16'd2,      32'd3000,       '0);           // zero elapsed time
        queue_cmd(ACT_TICK, 16'd2,      32'd100,        '0);
        queue_cmd(ACT_TICK, 16'd2,      32'd100,        '0);           // clock went back
        queue_cmd(ACT_TICK, 16'd2,      32'd30100,      '0);
        queue_cmd(ACT_TICK, 16'd2,      32'd30100,      '0);           // gap exactly 30 s
        queue_cmd(ACT_TICK, 16'd2,      32'd60101,      '0);
        queue_cmd(ACT_TICK, 16'd2,      32'd60101,      '0);           // gap over 30 s
        queue_cmd(ACT_TICK, 16'hFFFF,   32'hFFFF_FFFF,  '0);
        queue_cmd(ACT_TICK, 16'h8000,   32'hFFFF_FFFF,  DLY_MAX);
        queue_cmd(ACT_TICK, 16'd0,      32'hFFFF_FFFF,  '0);
        queue_cmd(ACT_INIT, 16'h5555,   32'h5555_5555,  31'h2AAA_AAAA);
        gen_now = 32'h5555_5555;
        queue_traffic(PER_PHASE);
        wait_drained();

        // Register settings, extremes first; the idle mix rotates per phase
        for (ph = 1; ph <= 5; ph++) begin
            case (ph)
                1: begin gap_v = '0;      ips_v = DLY_ONE; end
                2: begin gap_v = DLY_MAX; ips_v = DLY_MAX; end
                3: begin gap_v = DLY_W'($urandom_range(0, 3000)); ips_v = '0; end
                4: begin gap_v = DLY_W'($urandom()); ips_v = DLY_W'($urandom()); end
                default: begin gap_v = MAX_GAP_RST; ips_v = INIT_IPS_RST; end
            endcase
            write_reg(CFG_MAX_GAP_MS, gap_v);
            write_reg(CFG_INITIAL_IPS, ips_v);
            @(posedge i_clk);
            idle_mode = t_idle_mode'(ph % 4);
            queue_traffic(PER_PHASE / 2);
            // back-pressure: receiver holds off while the driver keeps offering
            if (ph == 4)
                hold_token++;
            // sender pause until the block has drained
            if (ph == 1)
                wait_drained();
            queue_traffic(PER_PHASE - PER_PHASE / 2);
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (result_due_q.size() != 0) begin
            $error("%0d predicted results never arrived", result_due_q.size());
            n_fail++;
        end
        if (n_fail == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/sctd_pkg.sv
rtl/core/sctd_in_if.sv
rtl/core/sctd_out_if.sv
rtl/core/sctd_mul.sv
rtl/core/sctd_div.sv
rtl/core/self_calibrating_tick_delay.sv
sim/tb.sv
